/* hw/rtl/treatment_phase_sequencer_assert.svh */
// Assertion macros used by the checker file of the treatment phase sequencer.
`ifndef TREATMENT_PHASE_SEQUENCER_ASSERT_SVH
`define TREATMENT_PHASE_SEQUENCER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define TPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define TPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/tps_pkg.sv */
// Package with the types, codes and constants of the treatment phase sequencer.
`timescale 1ns / 1ps
package tps_pkg;

  localparam int unsigned NUM_ALARMS = 20;
  localparam int unsigned ALARM_W = 20;
  localparam int unsigned CFG_W = 8;
  localparam int unsigned CFG_NUM = 8;
  localparam int unsigned CFG_IDX_W = $clog2(CFG_NUM);
  localparam logic [ALARM_W-1:0] ALARM_MASK = ALARM_W'((64'd1 << NUM_ALARMS) - 64'd1);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_FILL  = 3'd1,
    PH_FLOW2 = 3'd2,
    PH_FLOW3 = 3'd3,
    PH_FLOW4 = 3'd4,
    PH_FLOW5 = 3'd5,
    PH_FLOW6 = 3'd6,
    PH_DONE  = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    PATH_NONE        = 3'd0,
    PATH_FLUSH_OPEN  = 3'd1,
    PATH_FLUSH2_V4   = 3'd2,
    PATH_FLUSH1_V4   = 3'd3,
    PATH_FLUSH1_V134 = 3'd4,
    PATH_FLUSH2_V134 = 3'd5
  } path_t;

  typedef enum logic [2:0] {
    K_START  = 3'd0,
    K_STOP   = 3'd1,
    K_SECOND = 3'd2,
    K_MINUTE = 3'd3,
    K_HOUR   = 3'd4,
    K_ALARM  = 3'd5
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILL_LIMIT   = 3'd0,
    CFG_SECOND_LIMIT = 3'd1,
    CFG_THIRD_LIMIT  = 3'd2,
    CFG_FOURTH_LIMIT = 3'd3,
    CFG_FIFTH_LIMIT  = 3'd4,
    CFG_SIXTH_LIMIT  = 3'd5,
    CFG_TOTAL_MIN    = 3'd6,
    CFG_TOTAL_HOUR   = 3'd7
  } cfg_idx_t;

  localparam logic [CFG_W-1:0] CFG_RESET [CFG_NUM] = '{
    8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd240, 8'd4
  };

  function automatic path_t next_path(phase_t ph);
    path_t p;
    unique case (ph)
      PH_FILL:  p = PATH_FLUSH2_V4;
      PH_FLOW2: p = PATH_FLUSH1_V4;
      PH_FLOW3: p = PATH_FLUSH2_V4;
      PH_FLOW4: p = PATH_FLUSH1_V134;
      PH_FLOW5: p = PATH_FLUSH2_V134;
      PH_FLOW6: p = PATH_FLUSH2_V4;
      default:  p = PATH_NONE;
    endcase
    return p;
  endfunction

  function automatic phase_t next_phase(phase_t ph);
    phase_t n;
    unique case (ph)
      PH_FILL:  n = PH_FLOW2;
      PH_FLOW2: n = PH_FLOW3;
      PH_FLOW3: n = PH_FLOW4;
      PH_FLOW4: n = PH_FLOW5;
      PH_FLOW5: n = PH_FLOW6;
      PH_FLOW6: n = PH_FLOW2;
      default:  n = ph;
    endcase
    return n;
  endfunction

endpackage

/* hw/rtl/tps_if.sv */
// Valid/ready channel interfaces for the event items and the result items.
`timescale 1ns / 1ps
interface tps_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic        path_accepted;
  logic [19:0] alarm_active;

  modport source (output valid, kind, path_accepted, alarm_active, input ready);
  modport sink (input valid, kind, path_accepted, alarm_active, output ready);
endinterface

interface tps_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  phase;
  logic [2:0]  path_order;
  logic        start_confirm;
  logic        time_report;
  logic [7:0]  total_minutes;
  logic [7:0]  total_hours;
  logic [7:0]  seconds;
  logic [7:0]  remaining_minutes;
  logic [7:0]  remaining_hours;
  logic        completed;
  logic [19:0] new_alarms;

  modport source (
    output valid, phase, path_order, start_confirm, time_report, total_minutes,
           total_hours, seconds, remaining_minutes, remaining_hours, completed,
           new_alarms,
    input ready
  );
  modport sink (
    input valid, phase, path_order, start_confirm, time_report, total_minutes,
          total_hours, seconds, remaining_minutes, remaining_hours, completed,
          new_alarms,
    output ready
  );
endinterface

/* hw/rtl/treatment_phase_sequencer.sv */
// Top level of the treatment phase sequencer: event decode, counters and phase control.
// The block takes event items on in_ch (start, stop, second, minute and hour ticks,
// alarm) and returns exactly one result item on out_ch for every event item.
// Limits are written through cfg_we, cfg_index and cfg_wdata; a write lands at the
// rising edge where cfg_we is high and is meant to happen only while the block is idle.
// An accepted item sits in the input register while its state update and result are
// computed, and the result is stored in the output register and offered on out_ch.
// The block takes one item in every cycle while the receiver keeps out_ch ready;
// the input register and the output register form a two-stage pipeline whose
// ready is set by the output register. When the receiver stalls, the result
// holds on out_ch and the input register still takes one more item; after that
// in_ch.ready drops until out_ch drains.
// Reset clears the phase to idle, all counters and the raised alarm marks, and
// loads the default limits.
`timescale 1ns / 1ps
module treatment_phase_sequencer
  import tps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  tps_in_if.sink               in_ch,
  tps_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic [CFG_W-1:0]   cfg_r [CFG_NUM];

  logic               in_v_r;
  logic [2:0]         kind_r;
  logic               acc_r;
  logic [ALARM_W-1:0] alarm_r;

  phase_t             phase_r, phase_nxt;
  logic [7:0]         sec_r, sec_nxt;
  logic [8:0]         pmin_r, pmin_nxt;
  logic [8:0]         tmin_r, tmin_nxt;
  logic [7:0]         hour_r, hour_nxt;
  logic [ALARM_W-1:0] marks_r, marks_nxt;

  logic               out_v_r;
  phase_t             o_phase_r;
  path_t              o_path_r, path_nxt;
  logic               o_confirm_r, confirm_nxt;
  logic               o_report_r, report_nxt;
  logic [7:0]         o_tm_r, tm_nxt;
  logic [7:0]         o_th_r, th_nxt;
  logic [7:0]         o_sc_r, sc_nxt;
  logic [7:0]         o_rm_r, rm_nxt;
  logic [7:0]         o_rh_r, rh_nxt;
  logic               o_done_r, done_nxt;
  logic [ALARM_W-1:0] o_fresh_r, fresh_nxt;

  logic               out_free;
  logic               s1_fire;
  logic [ALARM_W-1:0] fresh;
  logic [7:0]         sec_inc;
  logic [8:0]         pmin_inc;
  logic [8:0]         tmin_inc;
  logic [CFG_IDX_W-1:0] lim_idx;

  assign out_free    = !out_v_r || out_ch.ready;
  assign s1_fire     = in_v_r && out_free;
  assign in_ch.ready = !in_v_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CFG_NUM; i++) begin
        cfg_r[i] <= CFG_RESET[i];
      end
    end else if (cfg_we) begin
      cfg_r[cfg_index] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      kind_r  <= in_ch.kind;
      acc_r   <= in_ch.path_accepted;
      alarm_r <= in_ch.alarm_active & ALARM_MASK;
    end
  end

  assign fresh    = alarm_r & ~marks_r;
  assign sec_inc  = (sec_r != 8'hFF) ? 8'(sec_r + 8'd1) : sec_r;
  assign pmin_inc = 9'(pmin_r + 9'd1);
  assign tmin_inc = 9'(tmin_r + 9'd1);
  assign lim_idx  = CFG_IDX_W'(3'(phase_r) - 3'd1);

  always_comb begin
    phase_nxt   = phase_r;
    sec_nxt     = sec_r;
    pmin_nxt    = pmin_r;
    tmin_nxt    = tmin_r;
    hour_nxt    = hour_r;
    marks_nxt   = marks_r;
    path_nxt    = PATH_NONE;
    confirm_nxt = 1'b0;
    report_nxt  = 1'b0;
    tm_nxt      = 8'd0;
    th_nxt      = 8'd0;
    sc_nxt      = 8'd0;
    rm_nxt      = 8'd0;
    rh_nxt      = 8'd0;
    done_nxt    = 1'b0;
    fresh_nxt   = '0;
    unique case (phase_r)
      PH_IDLE: begin
        if (kind_r == K_START) begin
          path_nxt = PATH_FLUSH_OPEN;
          if (acc_r) begin
            phase_nxt   = PH_FILL;
            pmin_nxt    = 9'd0;
            tmin_nxt    = 9'd0;
            confirm_nxt = 1'b1;
          end
        end else if (kind_r == K_ALARM) begin
          fresh_nxt = fresh;
          marks_nxt = marks_r | fresh;
        end
      end
      PH_DONE: begin
      end
      default: begin
        unique case (kind_r)
          K_STOP: begin
            sec_nxt  = 8'd0;
            pmin_nxt = 9'd0;
            tmin_nxt = 9'd0;
            hour_nxt = 8'd0;
          end
          K_SECOND: begin
            sec_nxt    = sec_inc;
            report_nxt = 1'b1;
            tm_nxt     = tmin_r[7:0];
            th_nxt     = hour_r;
            sc_nxt     = sec_inc;
            rm_nxt     = 8'(cfg_r[CFG_TOTAL_MIN] - tmin_r[7:0]);
            rh_nxt     = 8'(cfg_r[CFG_TOTAL_HOUR] - hour_r);
          end
          K_MINUTE: begin
            sec_nxt = 8'd0;
            if (tmin_r > {1'b0, cfg_r[CFG_TOTAL_MIN]}) begin
              pmin_nxt  = 9'd0;
              tmin_nxt  = 9'd0;
              hour_nxt  = 8'd0;
              phase_nxt = PH_DONE;
              done_nxt  = 1'b1;
            end else begin
              tmin_nxt = tmin_inc;
              if (pmin_inc > {1'b0, cfg_r[lim_idx]}) begin
                pmin_nxt = 9'd0;
                path_nxt = next_path(phase_r);
                if (acc_r) begin
                  phase_nxt = next_phase(phase_r);
                end
              end else begin
                pmin_nxt = pmin_inc;
              end
            end
          end
          K_HOUR: begin
            if (hour_r != 8'hFF) begin
              hour_nxt = 8'(hour_r + 8'd1);
            end
          end
          K_ALARM: begin
            fresh_nxt = fresh;
            marks_nxt = marks_r | fresh;
          end
          default: begin
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      sec_r   <= 8'd0;
      pmin_r  <= 9'd0;
      tmin_r  <= 9'd0;
      hour_r  <= 8'd0;
      marks_r <= '0;
    end else if (s1_fire) begin
      phase_r <= phase_nxt;
      sec_r   <= sec_nxt;
      pmin_r  <= pmin_nxt;
      tmin_r  <= tmin_nxt;
      hour_r  <= hour_nxt;
      marks_r <= marks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      o_phase_r   <= phase_nxt;
      o_path_r    <= path_nxt;
      o_confirm_r <= confirm_nxt;
      o_report_r  <= report_nxt;
      o_tm_r      <= tm_nxt;
      o_th_r      <= th_nxt;
      o_sc_r      <= sc_nxt;
      o_rm_r      <= rm_nxt;
      o_rh_r      <= rh_nxt;
      o_done_r    <= done_nxt;
      o_fresh_r   <= fresh_nxt;
    end
  end

  assign out_ch.valid             = out_v_r;
  assign out_ch.phase             = 3'(o_phase_r);
  assign out_ch.path_order        = 3'(o_path_r);
  assign out_ch.start_confirm     = o_confirm_r;
  assign out_ch.time_report       = o_report_r;
  assign out_ch.total_minutes     = o_tm_r;
  assign out_ch.total_hours       = o_th_r;
  assign out_ch.seconds           = o_sc_r;
  assign out_ch.remaining_minutes = o_rm_r;
  assign out_ch.remaining_hours   = o_rh_r;
  assign out_ch.completed         = o_done_r;
  assign out_ch.new_alarms        = o_fresh_r;

endmodule

/* hw/rtl/tps_checker.sv */
// Port-level checker for the treatment phase sequencer and its bind statement.
`timescale 1ns / 1ps
`include "treatment_phase_sequencer_assert.svh"
module tps_checker
  import tps_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_phase,
  input logic [2:0]  out_path_order,
  input logic        out_start_confirm,
  input logic        out_time_report,
  input logic [7:0]  out_total_minutes,
  input logic [7:0]  out_seconds,
  input logic        out_completed,
  input logic [19:0] out_new_alarms
);

  `TPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_phase) && $stable(out_new_alarms), "stalled result item changed")
  `TPS_ASSERT_NOW(a_done_phase, out_valid && out_completed, out_phase == 3'(PH_DONE) && !out_time_report, "completed item not in standby")
  `TPS_ASSERT_NOW(a_time_zero, out_valid && !out_time_report, out_total_minutes == 8'd0 && out_seconds == 8'd0, "time fields set without time report")
  `TPS_ASSERT_NOW(a_start_ok, out_valid && out_start_confirm, out_phase == 3'(PH_FILL) && out_path_order == 3'(PATH_FLUSH_OPEN), "start confirmed outside fill")
  `TPS_ASSERT_NOW(a_alarm_alone, out_valid && out_new_alarms != 20'd0, out_path_order == 3'(PATH_NONE) && !out_completed && !out_start_confirm, "alarm item carries other results")

endmodule

bind treatment_phase_sequencer tps_checker u_tps_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_phase         (out_ch.phase),
  .out_path_order    (out_ch.path_order),
  .out_start_confirm (out_ch.start_confirm),
  .out_time_report   (out_ch.time_report),
  .out_total_minutes (out_ch.total_minutes),
  .out_seconds       (out_ch.seconds),
  .out_completed     (out_ch.completed),
  .out_new_alarms    (out_ch.new_alarms)
);
